/* rtl/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg: shared definitions for the scalar kalman filter
// Default widths, register indexes, reset values and the command group
// that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

   // default formats: signed Q16.16 samples, unsigned Q1.16 gain
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // register index width of the configuration channel
   localparam int CSR_INDEX_WIDTH = 8;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROCESS_NOISE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEASURE_NOISE = 8'd1;

   // reset value of the process noise, about 0.001 in Q16.16
   localparam int PROCESS_NOISE_RESET = 66;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture the measurement
      logic predict;   // covariance prediction and innovation
      logic div_init;  // set up the gain division
      logic div_step;  // one quotient bit
      logic mul_init;  // fix the gain, clear the accumulators
      logic mul_step;  // one multiplier bit
      logic update;    // write back state and result
   } skf_cmd_type;

endpackage

/* rtl/skf_ifs.sv */
// ----------------------------------------------------------------------------
// skf_ifs: channel interfaces of the scalar kalman filter
// Measurement, result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------

// measurement channel
interface skf_req_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

// result channel
interface skf_rsp_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;
   logic        [FRAC_BITS:0]    gain;

   modport source (output valid, output estimate, output gain, input ready);
   modport sink   (input valid, input estimate, input gain, output ready);
endinterface

// register write channel
interface skf_csr_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic [skf_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]               data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/skf_ctrl.sv */
// ----------------------------------------------------------------------------
// skf_ctrl: sequencing controller of the scalar kalman filter
// Steps one measurement through prediction, gain division, the bit-serial
// multiplies and write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module skf_ctrl #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output skf_pkg::skf_cmd_type cmd
);
   import skf_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_MUL_INIT,
      ST_MULTIPLY,
      ST_UPDATE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;

   // commands decoded from the state
   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.load     = req_valid && (state_ff == ST_IDLE);
   assign cmd.predict  = (state_ff == ST_PREDICT);
   assign cmd.div_init = (state_ff == ST_DIV_INIT);
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.mul_init = (state_ff == ST_MUL_INIT);
   assign cmd.mul_step = (state_ff == ST_MULTIPLY);
   assign cmd.update   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   // state, iteration count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_PREDICT;
               end
            end
            ST_PREDICT: begin
               state_ff <= ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
               cnt_ff   <= CNT_W'(FRAC_BITS - 1);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_MUL_INIT;
               end
            end
            ST_MUL_INIT: begin
               cnt_ff   <= CNT_W'(FRAC_BITS);
               state_ff <= ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // at most one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.predict, cmd.div_init, cmd.div_step,
                cmd.mul_init, cmd.mul_step, cmd.update}))
      else $error("skf_ctrl: overlapping datapath commands");

   // one transaction at a time: no new measurement right after one is taken
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("skf_ctrl: measurement accepted while busy");

   // write-back never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || rsp_ready))
      else $error("skf_ctrl: pending result overwritten");

   // a result is raised by a write-back only
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.update))
      else $error("skf_ctrl: result valid without write-back");

endmodule

/* rtl/skf_datapath.sv */
// ----------------------------------------------------------------------------
// skf_datapath: arithmetic and state of the scalar kalman filter
// Holds the noise registers, estimate and covariance, a restoring divider
// for the gain and two shift-add multipliers for the updates.
// ----------------------------------------------------------------------------
module skf_datapath #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skf_pkg::skf_cmd_type                 cmd,
   input  logic signed [DATA_WIDTH-1:0]         measurement,
   input  logic                                 csr_write,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [DATA_WIDTH-1:0]                csr_data,
   output logic signed [DATA_WIDTH-1:0]         estimate,
   output logic [FRAC_BITS:0]                   gain
);
   import skf_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int ACC_W = DATA_WIDTH + FRAC_BITS + 1;

   localparam logic [F:0]       ONE     = {1'b1, {F{1'b0}}};
   localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (F - 1);
   localparam logic [W-1:0]     Q_RESET = W'(PROCESS_NOISE_RESET);
   localparam logic [W-1:0]     R_RESET = W'(1) << F;

   // configuration and filter state
   logic [W-1:0] q_ff;
   logic [W-1:0] r_ff;
   logic [W-1:0] x_ff;
   logic [W-1:0] p_ff;

   // per-transaction working registers
   logic [W-1:0]     z_ff;
   logic [W-1:0]     pp_ff;
   logic [W:0]       mag_ff;
   logic             neg_ff;
   logic [W:0]       den_ff;
   logic             den_zero_ff;
   logic             full_ff;
   logic [W+1:0]     rem_ff;
   logic [F-1:0]     quo_ff;
   logic [F:0]       gain_k_ff;
   logic [F:0]       kbits_ff;
   logic [F:0]       ckbits_ff;
   logic [ACC_W-1:0] acc_d_ff;
   logic [ACC_W-1:0] acc_p_ff;
   logic [W-1:0]     est_out_ff;
   logic [F:0]       gain_out_ff;

   // next values
   logic [W:0]       sum_pq;
   logic [W-1:0]     pp_in;
   logic [W:0]       diff;
   logic [W:0]       mag_in;
   logic [W:0]       den_in;
   logic [W+1:0]     rem_sh;
   logic             rem_ge;
   logic [W+1:0]     rem_in;
   logic [F:0]       k_in;
   logic [ACC_W-1:0] acc_d_in;
   logic [ACC_W-1:0] acc_p_in;
   logic [ACC_W-1:0] rnd_d;
   logic [ACC_W-1:0] rnd_p;
   logic [W:0]       delta;
   logic [W+1:0]     xn_full;
   logic [W-1:0]     xn_in;
   logic [W-1:0]     p_in;

   // predicted covariance, saturated, and the innovation magnitude
   always_comb begin
      sum_pq = {1'b0, p_ff} + {1'b0, q_ff};
      pp_in  = sum_pq[W] ? {W{1'b1}} : sum_pq[W-1:0];
      diff   = {z_ff[W-1], z_ff} - {x_ff[W-1], x_ff};
      mag_in = diff[W] ? (~diff + 1'b1) : diff;
   end

   // gain denominator and one restoring division step
   always_comb begin
      den_in = {1'b0, pp_ff} + {1'b0, r_ff};
      rem_sh = {rem_ff[W:0], 1'b0};
      rem_ge = rem_sh >= {1'b0, den_ff};
      rem_in = rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   // final gain with the zero-denominator and unit-gain cases
   always_comb begin
      priority if (den_zero_ff) begin
         k_in = '0;
      end else if (full_ff) begin
         k_in = ONE;
      end else begin
         k_in = {1'b0, quo_ff};
      end
   end

   // msb-first shift-add for gain*|z-x| and (one-gain)*pp
   always_comb begin
      acc_d_in = {acc_d_ff[ACC_W-2:0], 1'b0}
               + (kbits_ff[F] ? {{F{1'b0}}, mag_ff} : '0);
      acc_p_in = {acc_p_ff[ACC_W-2:0], 1'b0}
               + (ckbits_ff[F] ? {{(F+1){1'b0}}, pp_ff} : '0);
   end

   // rounding and write-back values
   always_comb begin
      rnd_d   = acc_d_ff + HALF;
      rnd_p   = acc_p_ff + HALF;
      delta   = rnd_d[F +: W+1];
      xn_full = neg_ff ? ({{2{x_ff[W-1]}}, x_ff} - {1'b0, delta})
                       : ({{2{x_ff[W-1]}}, x_ff} + {1'b0, delta});
      xn_in   = xn_full[W-1:0];
      p_in    = rnd_p[F +: W];
   end

   // noise registers and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= Q_RESET;
         r_ff <= R_RESET;
         x_ff <= '0;
         p_ff <= '0;
      end else begin
         if (csr_write && (csr_index == REG_PROCESS_NOISE)) begin
            q_ff <= csr_data;
         end
         if (csr_write && (csr_index == REG_MEASURE_NOISE)) begin
            r_ff <= csr_data;
         end
         if (cmd.update) begin
            x_ff <= xn_in;
            p_ff <= p_in;
         end
      end
   end

   // working registers and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         z_ff <= measurement;
      end
      if (cmd.predict) begin
         pp_ff  <= pp_in;
         mag_ff <= mag_in;
         neg_ff <= diff[W];
      end
      if (cmd.div_init) begin
         den_ff      <= den_in;
         den_zero_ff <= (den_in == '0);
         full_ff     <= ({1'b0, pp_ff} >= den_in);
         rem_ff      <= {2'b00, pp_ff};
         quo_ff      <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[F-2:0], rem_ge};
      end
      if (cmd.mul_init) begin
         gain_k_ff <= k_in;
         kbits_ff  <= k_in;
         ckbits_ff <= ONE - k_in;
         acc_d_ff  <= '0;
         acc_p_ff  <= '0;
      end
      if (cmd.mul_step) begin
         acc_d_ff  <= acc_d_in;
         acc_p_ff  <= acc_p_in;
         kbits_ff  <= {kbits_ff[F-1:0], 1'b0};
         ckbits_ff <= {ckbits_ff[F-1:0], 1'b0};
      end
      if (cmd.update) begin
         est_out_ff  <= xn_in;
         gain_out_ff <= gain_k_ff;
      end
   end

   assign estimate = est_out_ff;
   assign gain     = gain_out_ff;

   // the gain never exceeds one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_init |=> (gain_k_ff <= ONE))
      else $error("skf_datapath: gain above one");

   // the updated covariance never exceeds the prediction
   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (p_ff <= $past(pp_ff)))
      else $error("skf_datapath: covariance grew in update");

endmodule

/* rtl/scalar_kalman_filter.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional kalman filter, A = 1 and H = 1
// Filters signed fixed-point measurements and returns estimate and gain.
// ----------------------------------------------------------------------------
// One measurement is processed at a time. After acceptance it passes
// through prediction, gain division, the multiplies and write-back, and a
// new measurement is taken only once the controller is idle again. The
// gain comes from a restoring divider that forms one quotient bit a cycle
// (FRAC_BITS bits, 16 at the default Q16.16 format), and shift-add
// multipliers for the estimate and covariance updates take one gain bit a
// cycle (FRAC_BITS+1 bits). A finished result waits in an output register,
// and the next measurement is taken meanwhile; write-back stalls only if
// a result is still pending when the next one is ready. Noise registers
// are written through the csr channel, which is always ready; writes to
// unknown indexes are dropped. Writes are meant for when the filter is
// idle.
module scalar_kalman_filter #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   skf_req_if.sink      req_chan,
   skf_rsp_if.source    rsp_chan,
   skf_csr_if.sink      csr_chan
);
   import skf_pkg::*;

   skf_cmd_type cmd;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;

   // sequencing
   skf_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // arithmetic and state
   skf_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .measurement (req_chan.measurement),
      .csr_write   (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .estimate    (rsp_chan.estimate),
      .gain        (rsp_chan.gain)
   );

endmodule
